// ----- rtl/core/skvm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package skvm_pkg;

    // Store size and field widths.
    localparam int SLOTS_DEFAULT = 16;
    localparam int KEY_W         = 64;
    localparam int VAL_W         = 64;
    localparam int OP_W          = 2;

    // Request codes. The fourth code is a no-op that still reports found.
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;       // take the input beat and compare its key
        logic act;           // apply the request to the store
        logic rd_issue;      // read the value of the matching slot
        logic sweep_start;   // reset the compaction pointers
        logic sweep_step;    // advance compaction by one slot
        logic load_out;      // load the result register
        logic out_from_ram;  // result value comes from the value memory
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            hit;
        logic            full;
        logic            sweep_done;
        logic            out_free;
    } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/skvm_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module skvm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/skvm_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module skvm_datapath #(
    parameter int SLOTS = skvm_pkg::SLOTS_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire skvm_pkg::cmd_t               cmd,
    output skvm_pkg::sts_t                    sts,
    input  wire logic [skvm_pkg::OP_W-1:0]    in_op,
    input  wire logic [skvm_pkg::KEY_W-1:0]   in_key,
    input  wire logic [skvm_pkg::VAL_W-1:0]   in_value,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              out_found,
    output logic [skvm_pkg::VAL_W-1:0]        out_read_value,
    output logic                              out_status
);

    localparam int IW = $clog2(SLOTS);
    localparam int FW = $clog2(SLOTS + 1);

    // Captured request.
    logic [skvm_pkg::OP_W-1:0]  op_reg;
    logic [skvm_pkg::KEY_W-1:0] key_reg;
    logic [skvm_pkg::VAL_W-1:0] value_reg;
    logic [SLOTS-1:0]           match_reg;
    logic [SLOTS-1:0]           match_next;

    // Store: keys and valid marks in flip-flops, values in memory.
    logic [skvm_pkg::KEY_W-1:0] slot_key_reg [SLOTS];
    logic [SLOTS-1:0]           slot_valid_reg;
    logic [FW-1:0]              fill_reg;

    // Compaction pointers and the one-slot pipeline between read and write.
    logic [FW-1:0]              src_reg;
    logic [FW-1:0]              dst_reg;
    logic                       pend_reg;
    logic [skvm_pkg::KEY_W-1:0] pend_key_reg;

    // Result register.
    logic                       out_valid_reg;
    logic                       out_found_reg;
    logic                       out_status_reg;
    logic [skvm_pkg::VAL_W-1:0] out_value_reg;

    logic [SLOTS-1:0]           hit_onehot;
    logic [IW-1:0]              hit_idx;
    logic                       hit;
    logic                       full;
    logic                       sweep_done;
    logic                       src_live;
    logic                       append;
    logic                       drop;
    logic                       out_free;

    logic                       ram_wr_en;
    logic [IW-1:0]              ram_wr_addr;
    logic [skvm_pkg::VAL_W-1:0] ram_wr_data;
    logic                       ram_rd_en;
    logic [IW-1:0]              ram_rd_addr;
    logic [skvm_pkg::VAL_W-1:0] ram_rd_data;

    // Compare the incoming key against every slot at once.
    always_comb
    begin
        for (int k = 0; k < SLOTS; k++)
        begin
            match_next[k] = slot_valid_reg[k] && (slot_key_reg[k] == in_key);
        end
    end

    // Keep the lowest matching slot and encode its index.
    assign hit_onehot = match_reg & (~match_reg + {{(SLOTS-1){1'b0}}, 1'b1});
    assign hit        = |match_reg;

    always_comb
    begin
        hit_idx = '0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (hit_onehot[k])
            begin
                hit_idx = hit_idx | IW'(k);
            end
        end
    end

    assign full       = (fill_reg == FW'(SLOTS));
    assign src_live   = (src_reg != fill_reg);
    assign sweep_done = !src_live && !pend_reg;
    assign append     = (op_reg == skvm_pkg::OP_ADD) && !hit && !full;
    assign drop       = (op_reg == skvm_pkg::OP_ADD) && !hit && full;
    assign out_free   = !out_valid_reg || out_ready;

    assign sts.op         = op_reg;
    assign sts.hit        = hit;
    assign sts.full       = full;
    assign sts.sweep_done = sweep_done;
    assign sts.out_free   = out_free;

    // Value memory port control.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = '0;
        ram_wr_data = value_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = hit_idx;
        if (cmd.rd_issue)
        begin
            ram_rd_en = 1'b1;
        end
        if (cmd.sweep_step && src_live)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = src_reg[IW-1:0];
        end
        if (cmd.sweep_step && pend_reg)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = dst_reg[IW-1:0];
            ram_wr_data = ram_rd_data;
        end
        if (cmd.act && (op_reg == skvm_pkg::OP_ADD) && hit)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = hit_idx;
        end
        if (cmd.act && append)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_reg[IW-1:0];
        end
    end

    skvm_ram #(
        .WIDTH (skvm_pkg::VAL_W),
        .DEPTH (SLOTS)
    ) u_value_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Valid marks, fill mark, compaction pointers and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            fill_reg       <= '0;
            src_reg        <= '0;
            dst_reg        <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.act && append)
            begin
                slot_valid_reg[fill_reg[IW-1:0]] <= 1'b1;
                fill_reg                         <= fill_reg + FW'(1);
            end
            if (cmd.act && (op_reg == skvm_pkg::OP_DELETE))
            begin
                slot_valid_reg <= slot_valid_reg & ~hit_onehot;
            end
            if (cmd.sweep_start)
            begin
                src_reg  <= '0;
                dst_reg  <= '0;
                pend_reg <= 1'b0;
            end
            if (cmd.sweep_step)
            begin
                if (sweep_done)
                begin
                    // Everything at or above the new fill mark is empty.
                    for (int k = 0; k < SLOTS; k++)
                    begin
                        if (FW'(k) >= dst_reg)
                        begin
                            slot_valid_reg[k] <= 1'b0;
                        end
                    end
                    fill_reg <= dst_reg;
                end
                else
                begin
                    if (src_live)
                    begin
                        pend_reg <= slot_valid_reg[src_reg[IW-1:0]];
                        src_reg  <= src_reg + FW'(1);
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg)
                    begin
                        slot_valid_reg[dst_reg[IW-1:0]] <= 1'b1;
                        dst_reg                         <= dst_reg + FW'(1);
                    end
                end
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload: request, keys, compaction key stage and result fields.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_op;
            key_reg   <= in_key;
            value_reg <= in_value;
            match_reg <= match_next;
        end
        if (cmd.act && append)
        begin
            slot_key_reg[fill_reg[IW-1:0]] <= key_reg;
        end
        if (cmd.sweep_step && src_live)
        begin
            pend_key_reg <= slot_key_reg[src_reg[IW-1:0]];
        end
        if (cmd.sweep_step && pend_reg)
        begin
            slot_key_reg[dst_reg[IW-1:0]] <= pend_key_reg;
        end
        if (cmd.load_out)
        begin
            out_found_reg  <= hit;
            out_status_reg <= drop;
            out_value_reg  <= cmd.out_from_ram ? ram_rd_data : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_found      = out_found_reg;
    assign out_status     = out_status_reg;
    assign out_read_value = out_value_reg;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(SLOTS))
        else $error("fill mark beyond store size");

    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_onehot))
        else $error("more than one slot selected as the match");

    a_sweep_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sweep_step && sweep_done) |=> (fill_reg == $past(dst_reg)))
        else $error("fill mark not set to compacted count");

    a_dst_behind: assert property (@(posedge clk) disable iff (!rst_n)
        dst_reg <= src_reg)
        else $error("compaction write pointer passed the read pointer");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/skvm_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module skvm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire skvm_pkg::sts_t sts,
    output skvm_pkg::cmd_t      cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_RES   = 4'b0010,
        ST_READ  = 4'b0100,
        ST_SWEEP = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   compacted_reg;
    logic   compacted_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next     = state_reg;
        compacted_next = compacted_reg;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture    = 1'b1;
                    compacted_next = 1'b0;
                    state_next     = ST_RES;
                end
            end
            ST_RES:
            begin
                if ((sts.op == skvm_pkg::OP_LOOKUP) && sts.hit)
                begin
                    cmd.rd_issue = 1'b1;
                    state_next   = ST_READ;
                end
                else if ((sts.op == skvm_pkg::OP_ADD) && !sts.hit && sts.full
                         && !compacted_reg)
                begin
                    cmd.sweep_start = 1'b1;
                    state_next      = ST_SWEEP;
                end
                else if (sts.out_free)
                begin
                    cmd.act      = 1'b1;
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_READ:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out     = 1'b1;
                    cmd.out_from_ram = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done)
                begin
                    compacted_next = 1'b1;
                    state_next     = ST_RES;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            compacted_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            compacted_reg <= compacted_next;
        end
    end

`ifndef ASSERT_OFF
    a_accept_to_res: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_RES))
        else $error("accepted beat not followed by resolve");

    a_sweep_once: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP && sts.sweep_done) |=>
            (state_reg == ST_RES && compacted_reg))
        else $error("compaction did not return to resolve");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> sts.out_free)
        else $error("result loaded over an untaken result");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/small_key_value_map_top.sv -----
// Key/value map over a fixed store of SLOTS slots with 64-bit keys and values.
// Requests enter on the s_ stream: s_tuser carries the opcode (lookup, add or
// delete), s_tdata the key and the value to bind. Each request gives exactly
// one result beat on the m_ stream: m_tdata is the value read on a lookup hit
// (else zero), m_tuser carries found and the add-dropped status.
// A key is compared against all slots in parallel when the beat is taken, and
// the result is registered in the resolve state once the output register is
// free. A lookup that hits goes through a read state first, since the value
// comes through the registered read port of the value memory. An add of a new
// key on a full store first compacts the store one slot per cycle. A new
// request is taken only once the block has returned to idle.
// Reset empties the map at once; no clearing pass runs.
// When the receiver stalls, the result waits in the output register while the
// next request is taken and worked up to the point of delivering its result;
// the block then holds until the waiting beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module small_key_value_map_top #(
    parameter int SLOTS = skvm_pkg::SLOTS_DEFAULT
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // lookup_key, bind_value
    input  wire logic [1:0]   s_tuser,   // opcode
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [63:0]       m_tdata,   // read_value
    output logic [1:0]        m_tuser    // found, status
);

    skvm_pkg::cmd_t cmd;
    skvm_pkg::sts_t sts;
    logic           found;
    logic           status;

    skvm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    skvm_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .in_op          (s_tuser),
        .in_key         (s_tdata[63:0]),
        .in_value       (s_tdata[127:64]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_found      (found),
        .out_read_value (m_tdata),
        .out_status     (status)
    );

    assign m_tuser = {status, found};

endmodule

`default_nettype wire
